FILE: sv/aca_pkg.sv
// ----------------------------------------------------------------------------
// Arena chunk allocator package
// Shared constants, codes and record types of the chunk table.
// ----------------------------------------------------------------------------
`default_nettype none

package aca_pkg;

  // Fixed arena geometry.
  localparam int unsigned HEADER_BYTES = 40;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned ARENA_BYTES  = 65536;
  localparam int unsigned MAX_CHUNKS   = 1024;

  // Largest arena that init may build.
  localparam int unsigned ARENA_CAP = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;

  // Round-up reciprocal for the alignment divide, exact for 17-bit dividends.
  localparam int unsigned ALIGN_SH  = 17 + $clog2(ALIGN_BYTES);
  localparam int unsigned ALIGN_MUL = ((1 << ALIGN_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int unsigned MUL_W     = ALIGN_SH + 1;

  localparam logic [17:0] HDR18     = 18'(HEADER_BYTES);
  localparam logic [17:0] SPLIT_MIN = 18'(HEADER_BYTES + ALIGN_BYTES);

  typedef enum logic [1:0] {
    FUNC_INIT    = 2'd0,
    FUNC_ALLOC   = 2'd1,
    FUNC_FREE    = 2'd2,
    FUNC_REALLOC = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    POL_FIRST     = 2'd0,
    POL_BEST      = 2'd1,
    POL_WORST     = 2'd2,
    POL_FIRST_ALT = 2'd3
  } policy_e;

  typedef enum logic {
    REG_FIT_POLICY  = 1'b0,
    REG_ARENA_BYTES = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_INIT_WR,
    S_IDLE,
    S_ALIGN_MUL,
    S_ALIGN_SCALE,
    S_SCAN,
    S_SCAN_LAST,
    S_DECIDE,
    S_COMMIT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    STEP_ALLOC,
    STEP_LOOKUP,
    STEP_RESIZE,
    STEP_MERGE
  } step_e;

  // One row of the chunk table.
  typedef struct packed {
    logic        valid;
    logic        used;
    logic [15:0] off;
    logic [16:0] size;
    logic [31:0] stamp;
  } entry_t;

  // Keys that steer one table walk.
  typedef struct packed {
    logic [15:0] blk;
    logic [16:0] key_at;
    logic [15:0] key_bf;
    logic [16:0] rs;
    logic [16:0] avail;
    policy_e     policy;
  } scan_key_t;

  // Findings of one table walk.
  typedef struct packed {
    logic   used_f;
    entry_t used_e;
    logic   at_f;
    entry_t at_e;
    logic   bf_f;
    entry_t bf_e;
    logic   slot_f;
    logic   sel_f;
    entry_t sel_e;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: sv/aca_scan.sv
// ----------------------------------------------------------------------------
// Chunk table walk matcher
// Looks at one table row per cycle and keeps the first used block at a
// given data address, the chunk at a given offset, the chunk ending at a
// given offset, the first empty row and the fit search choice.
// ----------------------------------------------------------------------------
`default_nettype none

module aca_scan #(
  parameter int unsigned IdxW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               rd_vld_i,
  input  logic [IdxW-1:0]    rd_idx_i,
  input  aca_pkg::entry_t    rd_e_i,
  input  aca_pkg::scan_key_t key_i,
  output aca_pkg::scan_res_t res_o,
  output logic [IdxW-1:0]    used_idx_o,
  output logic [IdxW-1:0]    at_idx_o,
  output logic [IdxW-1:0]    bf_idx_o,
  output logic [IdxW-1:0]    slot_idx_o,
  output logic [IdxW-1:0]    sel_idx_o
);
  import aca_pkg::*;

  logic            used_f_q, at_f_q, bf_f_q, slot_f_q, hit_f_q, pick_f_q;
  entry_t          used_e_q, at_e_q, bf_e_q, hit_e_q, pick_e_q;
  logic [IdxW-1:0] used_idx_q, at_idx_q, bf_idx_q, slot_idx_q, hit_idx_q, pick_idx_q;

  logic [17:0] row_end;
  logic        m_used, m_at, m_bf, m_slot, cand, hit_upd, pick_upd;

  // Row matchers.
  assign row_end = {2'b0, rd_e_i.off} + HDR18 + {1'b0, rd_e_i.size};
  assign m_used  = rd_e_i.valid && rd_e_i.used &&
                   ({2'b0, rd_e_i.off} + HDR18 == {2'b0, key_i.blk});
  assign m_at    = rd_e_i.valid && ({1'b0, rd_e_i.off} == key_i.key_at);
  assign m_bf    = rd_e_i.valid && (row_end == {2'b0, key_i.key_bf});
  assign m_slot  = !rd_e_i.valid;
  assign cand    = rd_e_i.valid && !rd_e_i.used && (rd_e_i.size >= key_i.rs);

  // Fit search. Rows come in ascending order, so a later row only wins a
  // stamp tie-break with a strictly larger stamp.
  always_comb begin
    hit_upd  = 1'b0;
    pick_upd = 1'b0;
    if (cand) begin
      case (key_i.policy)
        POL_BEST: begin
          if (rd_e_i.size == key_i.rs) begin
            hit_upd = !hit_f_q || (rd_e_i.stamp > hit_e_q.stamp);
          end else begin
            pick_upd = !pick_f_q || (rd_e_i.size < pick_e_q.size) ||
                       ((rd_e_i.size == pick_e_q.size) && (rd_e_i.stamp > pick_e_q.stamp));
          end
        end
        POL_WORST: begin
          if (rd_e_i.size == key_i.avail) begin
            hit_upd = !hit_f_q || (rd_e_i.stamp > hit_e_q.stamp);
          end else if (rd_e_i.size != 17'd0) begin
            pick_upd = !pick_f_q || (rd_e_i.size > pick_e_q.size) ||
                       ((rd_e_i.size == pick_e_q.size) && (rd_e_i.stamp > pick_e_q.stamp));
          end
        end
        default: begin
          pick_upd = !pick_f_q || (rd_e_i.stamp > pick_e_q.stamp);
        end
      endcase
    end
  end

  // Found flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_f_q <= 1'b0;
      at_f_q   <= 1'b0;
      bf_f_q   <= 1'b0;
      slot_f_q <= 1'b0;
      hit_f_q  <= 1'b0;
      pick_f_q <= 1'b0;
    end else if (start_i) begin
      used_f_q <= 1'b0;
      at_f_q   <= 1'b0;
      bf_f_q   <= 1'b0;
      slot_f_q <= 1'b0;
      hit_f_q  <= 1'b0;
      pick_f_q <= 1'b0;
    end else if (rd_vld_i) begin
      if (m_used) used_f_q <= 1'b1;
      if (m_at) at_f_q <= 1'b1;
      if (m_bf) bf_f_q <= 1'b1;
      if (m_slot) slot_f_q <= 1'b1;
      if (hit_upd) hit_f_q <= 1'b1;
      if (pick_upd) pick_f_q <= 1'b1;
    end
  end

  // Captured rows and their indexes.
  always_ff @(posedge clk_i) begin
    if (rd_vld_i && !start_i) begin
      if (m_used && !used_f_q) begin
        used_e_q   <= rd_e_i;
        used_idx_q <= rd_idx_i;
      end
      if (m_at && !at_f_q) begin
        at_e_q   <= rd_e_i;
        at_idx_q <= rd_idx_i;
      end
      if (m_bf && !bf_f_q) begin
        bf_e_q   <= rd_e_i;
        bf_idx_q <= rd_idx_i;
      end
      if (m_slot && !slot_f_q) begin
        slot_idx_q <= rd_idx_i;
      end
      if (hit_upd) begin
        hit_e_q   <= rd_e_i;
        hit_idx_q <= rd_idx_i;
      end
      if (pick_upd) begin
        pick_e_q   <= rd_e_i;
        pick_idx_q <= rd_idx_i;
      end
    end
  end

  // An exact hit takes precedence over the running pick.
  assign res_o.used_f = used_f_q;
  assign res_o.used_e = used_e_q;
  assign res_o.at_f   = at_f_q;
  assign res_o.at_e   = at_e_q;
  assign res_o.bf_f   = bf_f_q;
  assign res_o.bf_e   = bf_e_q;
  assign res_o.slot_f = slot_f_q;
  assign res_o.sel_f  = hit_f_q || pick_f_q;
  assign res_o.sel_e  = hit_f_q ? hit_e_q : pick_e_q;

  assign used_idx_o = used_idx_q;
  assign at_idx_o   = at_idx_q;
  assign bf_idx_o   = bf_idx_q;
  assign slot_idx_o = slot_idx_q;
  assign sel_idx_o  = hit_f_q ? hit_idx_q : pick_idx_q;

endmodule

`default_nettype wire

FILE: sv/arena_chunk_allocator.sv
// ----------------------------------------------------------------------------
// Arena chunk allocator
// Heap manager for a byte arena with first, best and worst fit and merging.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (tuser selects init, alloc, free or
// realloc) and one result per request leaves on the m_axis channel. The
// cfg channel writes the fit policy and the arena size; it is always ready.
// All chunk rows sit in one table memory with a registered read.
// Every alloc, free and realloc request walks that table one row per cycle;
// the walk loop sets the throughput. The work of each request:
//   alloc:   one walk.
//   free:    up to two walks.
//   realloc: up to three walks.
//   init:    a sweep that clears every row, then the first chunk is written.
// Only one request is in flight. After reset the same clearing sweep runs
// before the first request is taken. A finished result moves into the
// output register and the block accepts the next request in the cycle
// after; if the receiver stalls with a result still held, the next finished
// result waits until that register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module arena_chunk_allocator #(
  parameter int unsigned MaxChunks = aca_pkg::MAX_CHUNKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // request_size[16:0], block_address[32:17]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // data_address[15:0], copy_bytes[32:16],
                                     // free_bytes[49:33]
  output logic [1:0]  m_axis_tuser,  // ok[0], moved[1]
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  import aca_pkg::*;

  localparam int unsigned IdxW = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxChunks - 1);

  // Control state.
  state_e          state_q, state_d;
  step_e           step_q;
  logic [IdxW-1:0] idx_q;
  logic [1:0]      wq_cnt_q;
  logic            rd_vld_q, out_valid_q, init_q, go_scan_q;
  policy_e         policy_q;
  logic [16:0]     arena_q, avail_q;
  logic [31:0]     stamp_q;

  // Request payload and work registers.
  func_e             func_q;
  logic [16:0]       req_q, rs_q;
  logic [15:0]       blk_q;
  logic [17+MUL_W-1:0] prod_q;
  logic [17:0]       align_rs;
  logic [IdxW-1:0]   n_idx_q, rd_idx_q;
  entry_t            n_e_q, rd_e_q;
  logic              ok_q, moved_q;
  logic [15:0]       addr_q;
  logic [16:0]       copy_q;
  logic              out_ok_q, out_moved_q;
  logic [15:0]       out_addr_q;
  logic [16:0]       out_copy_q, out_free_q;

  // Pending row writes of one decision.
  logic            wq_en_q  [3];
  logic [IdxW-1:0] wq_idx_q [3];
  entry_t          wq_dat_q [3];

  // Table memory.
  entry_t          mem [MaxChunks];
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_wa, mem_ra;
  entry_t          mem_wd;

  // Walk matcher.
  scan_key_t       skey;
  scan_res_t       sres;
  logic            scan_start;
  logic [IdxW-1:0] s_used_idx, s_at_idx, s_bf_idx, s_slot_idx, s_sel_idx;

  // Handshakes.
  logic in_fire, out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;
  assign scan_start    = (state_d == S_SCAN) && (state_q != S_SCAN);

  // Init size and the first chunk.
  logic [16:0] init_a;
  logic        init_ok;
  entry_t      init_e;

  assign init_a       = (arena_q > 17'(ARENA_CAP)) ? 17'(ARENA_CAP) : arena_q;
  assign init_ok      = {1'b0, init_a} > HDR18;
  assign init_e.valid = 1'b1;
  assign init_e.used  = 1'b0;
  assign init_e.off   = 16'd0;
  assign init_e.size  = 17'({1'b0, init_a} - HDR18);
  assign init_e.stamp = 32'd1;

  // Keys for the walk over the table.
  assign skey.blk    = blk_q;
  assign skey.key_at = 17'({2'b0, n_e_q.off} + HDR18 + {1'b0, n_e_q.size});
  assign skey.key_bf = n_e_q.off;
  assign skey.rs     = rs_q;
  assign skey.avail  = avail_q;
  assign skey.policy = policy_q;

  aca_scan #(
    .IdxW (IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .rd_vld_i   (rd_vld_q),
    .rd_idx_i   (rd_idx_q),
    .rd_e_i     (rd_e_q),
    .key_i      (skey),
    .res_o      (sres),
    .used_idx_o (s_used_idx),
    .at_idx_o   (s_at_idx),
    .bf_idx_o   (s_bf_idx),
    .slot_idx_o (s_slot_idx),
    .sel_idx_o  (s_sel_idx)
  );

  // Allocation out of the chosen free chunk, splitting off a tail if it holds
  // a header plus one alignment unit and an empty row exists.
  logic        al_ok, al_split;
  logic [17:0] al_rest, al_free;
  entry_t      al_new, al_n;
  logic [16:0] al_avail;

  assign al_ok    = sres.sel_f && (rs_q <= avail_q);
  assign al_rest  = {1'b0, sres.sel_e.size} - {1'b0, rs_q};
  assign al_split = sres.slot_f && (al_rest >= SPLIT_MIN);
  assign al_free  = al_rest - HDR18;
  assign al_avail = 17'({1'b0, avail_q} - {1'b0, sres.sel_e.size} +
                        (al_split ? al_free : 18'd0));

  always_comb begin
    al_new.valid = 1'b1;
    al_new.used  = 1'b0;
    al_new.off   = 16'({2'b0, sres.sel_e.off} + HDR18 + {1'b0, rs_q});
    al_new.size  = al_free[16:0];
    al_new.stamp = stamp_q + 32'd1;
    al_n         = sres.sel_e;
    al_n.used    = 1'b1;
    if (al_split) al_n.size = rs_q;
  end

  // In-place growth into a free successor.
  logic [17:0] gr_ex, gr_room, gr_rest;
  logic        gr_ok, gr_keep;
  entry_t      gr_e, gr_n;
  logic [16:0] gr_avail;

  assign gr_ex    = {1'b0, rs_q} - {1'b0, n_e_q.size};
  assign gr_room  = HDR18 + {1'b0, sres.at_e.size};
  assign gr_ok    = sres.at_f && !sres.at_e.used && (gr_room >= gr_ex);
  assign gr_rest  = gr_room - gr_ex;
  assign gr_keep  = gr_rest >= SPLIT_MIN;
  assign gr_avail = 17'({1'b0, avail_q} - {1'b0, sres.at_e.size} +
                        (gr_keep ? (gr_rest - HDR18) : 18'd0));

  always_comb begin
    gr_e       = sres.at_e;
    gr_e.valid = 1'b0;
    if (gr_keep) begin
      gr_e.valid = 1'b1;
      gr_e.used  = 1'b0;
      gr_e.off   = 16'({2'b0, sres.at_e.off} + gr_ex);
      gr_e.size  = 17'(gr_rest - HDR18);
      gr_e.stamp = stamp_q + 32'd1;
    end
    gr_n      = n_e_q;
    gr_n.size = gr_keep ? rs_q : 17'({1'b0, n_e_q.size} + gr_room);
  end

  // Release with merging into the next and then the previous free neighbor.
  logic        mg_nx, mg_pv;
  logic [16:0] mg_nsz, mg_avail;
  entry_t      mg_n, mg_at, mg_bf;

  assign mg_nx    = sres.at_f && !sres.at_e.used;
  assign mg_pv    = sres.bf_f && !sres.bf_e.used;
  assign mg_nsz   = 17'({1'b0, n_e_q.size} +
                        (mg_nx ? (HDR18 + {1'b0, sres.at_e.size}) : 18'd0));
  assign mg_avail = 17'({1'b0, avail_q} + {1'b0, n_e_q.size} +
                        (mg_nx ? HDR18 : 18'd0) + (mg_pv ? HDR18 : 18'd0));

  always_comb begin
    mg_n.valid  = !mg_pv;
    mg_n.used   = 1'b0;
    mg_n.off    = n_e_q.off;
    mg_n.size   = mg_nsz;
    mg_n.stamp  = stamp_q + 32'd1;
    mg_at       = sres.at_e;
    mg_at.valid = 1'b0;
    mg_bf       = sres.bf_e;
    mg_bf.size  = 17'({1'b0, sres.bf_e.size} + HDR18 + {1'b0, mg_nsz});
  end

  // Decision after a walk: row writes, counters, result and what follows.
  logic            dec_wen  [3];
  logic [IdxW-1:0] dec_widx [3];
  entry_t          dec_wdat [3];
  logic [16:0]     dec_avail;
  logic [31:0]     dec_stamp;
  logic            dec_ok, dec_moved, dec_scan;
  logic [15:0]     dec_addr;
  logic [16:0]     dec_copy;
  step_e           dec_step;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dec_wen[k]  = 1'b0;
      dec_widx[k] = '0;
      dec_wdat[k] = '0;
    end
    dec_avail = avail_q;
    dec_stamp = stamp_q;
    dec_ok    = ok_q;
    dec_moved = moved_q;
    dec_addr  = addr_q;
    dec_copy  = copy_q;
    dec_scan  = 1'b0;
    dec_step  = step_q;
    unique case (step_q)
      STEP_ALLOC: begin
        if (al_ok) begin
          dec_wen[0]  = al_split;
          dec_widx[0] = s_slot_idx;
          dec_wdat[0] = al_new;
          dec_wen[1]  = 1'b1;
          dec_widx[1] = s_sel_idx;
          dec_wdat[1] = al_n;
          dec_avail   = al_avail;
          dec_stamp   = al_split ? (stamp_q + 32'd1) : stamp_q;
          dec_ok      = 1'b1;
          dec_addr    = 16'({2'b0, sres.sel_e.off} + HDR18);
        end
      end
      STEP_LOOKUP: begin
        if (sres.used_f) begin
          if (func_q == FUNC_FREE) begin
            dec_scan = 1'b1;
            dec_step = STEP_MERGE;
          end else if (rs_q > avail_q) begin
            dec_ok = 1'b0;
          end else if (sres.used_e.size >= rs_q) begin
            dec_ok   = 1'b1;
            dec_addr = blk_q;
          end else begin
            dec_scan = 1'b1;
            dec_step = STEP_RESIZE;
          end
        end
      end
      STEP_RESIZE: begin
        if (gr_ok) begin
          dec_wen[0]  = 1'b1;
          dec_widx[0] = s_at_idx;
          dec_wdat[0] = gr_e;
          dec_wen[1]  = 1'b1;
          dec_widx[1] = n_idx_q;
          dec_wdat[1] = gr_n;
          dec_avail   = gr_avail;
          dec_stamp   = gr_keep ? (stamp_q + 32'd1) : stamp_q;
          dec_ok      = 1'b1;
          dec_addr    = blk_q;
        end else if (al_ok) begin
          dec_wen[0]  = al_split;
          dec_widx[0] = s_slot_idx;
          dec_wdat[0] = al_new;
          dec_wen[1]  = 1'b1;
          dec_widx[1] = s_sel_idx;
          dec_wdat[1] = al_n;
          dec_avail   = al_avail;
          dec_stamp   = al_split ? (stamp_q + 32'd1) : stamp_q;
          dec_ok      = 1'b1;
          dec_moved   = 1'b1;
          dec_copy    = n_e_q.size;
          dec_addr    = 16'({2'b0, sres.sel_e.off} + HDR18);
          dec_scan    = 1'b1;
          dec_step    = STEP_MERGE;
        end
      end
      STEP_MERGE: begin
        dec_wen[0]  = 1'b1;
        dec_widx[0] = n_idx_q;
        dec_wdat[0] = mg_n;
        dec_wen[1]  = mg_nx;
        dec_widx[1] = s_at_idx;
        dec_wdat[1] = mg_at;
        dec_wen[2]  = mg_pv;
        dec_widx[2] = s_bf_idx;
        dec_wdat[2] = mg_bf;
        dec_avail   = mg_avail;
        dec_stamp   = stamp_q + 32'd1;
        dec_ok      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (idx_q == LastIdx) state_d = init_q ? S_INIT_WR : S_IDLE;
      end
      S_INIT_WR: state_d = S_DONE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (func_e'(s_axis_tuser))
            FUNC_INIT: state_d = S_CLEAR;
            FUNC_FREE: state_d = S_SCAN;
            default:   state_d = S_ALIGN_MUL;
          endcase
        end
      end
      S_ALIGN_MUL:   state_d = S_ALIGN_SCALE;
      S_ALIGN_SCALE: state_d = S_SCAN;
      S_SCAN: begin
        if (idx_q == LastIdx) state_d = S_SCAN_LAST;
      end
      S_SCAN_LAST: state_d = S_DECIDE;
      S_DECIDE:    state_d = S_COMMIT;
      S_COMMIT: begin
        if (wq_cnt_q == 2'd2) state_d = go_scan_q ? S_SCAN : S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Table port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = idx_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_q;
      end
      S_INIT_WR: begin
        mem_we = init_ok;
        mem_wd = init_e;
      end
      S_SCAN: begin
        mem_re = 1'b1;
      end
      S_COMMIT: begin
        mem_we = wq_en_q[wq_cnt_q];
        mem_wa = wq_idx_q[wq_cnt_q];
        mem_wd = wq_dat_q[wq_cnt_q];
      end
      default: begin
      end
    endcase
  end

  // Table memory: one write and one registered read per cycle. The sequencer
  // never reads and writes in the same cycle, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      rd_e_q   <= mem[mem_ra];
      rd_idx_q <= mem_ra;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= STEP_ALLOC;
      idx_q       <= '0;
      wq_cnt_q    <= 2'd0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      init_q      <= 1'b0;
      go_scan_q   <= 1'b0;
      policy_q    <= POL_FIRST;
      arena_q     <= 17'h10000;
      avail_q     <= 17'd0;
      stamp_q     <= 32'd0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == S_SCAN);

      // Configuration transactions.
      if (cfg_valid_i) begin
        unique case (reg_e'(cfg_index_i))
          REG_FIT_POLICY:  policy_q <= policy_e'(cfg_data_i[1:0]);
          REG_ARENA_BYTES: arena_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // Row counter shared by the clearing sweep and the table walk.
      if ((state_q == S_CLEAR) || (state_q == S_SCAN)) begin
        idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
      end

      if (in_fire) begin
        init_q <= (func_e'(s_axis_tuser) == FUNC_INIT);
        step_q <= STEP_LOOKUP;
      end
      if (state_q == S_ALIGN_SCALE) begin
        step_q <= (func_q == FUNC_ALLOC) ? STEP_ALLOC : STEP_LOOKUP;
      end

      if (state_q == S_INIT_WR) begin
        avail_q <= init_ok ? init_e.size : 17'd0;
        stamp_q <= init_ok ? 32'd1 : 32'd0;
      end

      if (state_q == S_DECIDE) begin
        avail_q   <= dec_avail;
        stamp_q   <= dec_stamp;
        go_scan_q <= dec_scan;
        step_q    <= dec_step;
        wq_cnt_q  <= 2'd0;
      end
      if (state_q == S_COMMIT) begin
        wq_cnt_q <= (wq_cnt_q == 2'd2) ? 2'd0 : wq_cnt_q + 2'd1;
      end

      // Output register.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Aligned size before saturation; it reaches 18 bits only for requests
  // near the top of the 17-bit range.
  assign align_rs = 18'(prod_q[ALIGN_SH +: 18] * 18'(ALIGN_BYTES));

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q  <= func_e'(s_axis_tuser);
      req_q   <= s_axis_tdata[16:0];
      blk_q   <= s_axis_tdata[32:17];
      ok_q    <= 1'b0;
      moved_q <= 1'b0;
      addr_q  <= 16'd0;
      copy_q  <= 17'd0;
    end

    // Align up: multiply by the reciprocal, then scale the quotient back.
    if (state_q == S_ALIGN_MUL) begin
      prod_q <= (17 + MUL_W)'({1'b0, req_q} + 18'(ALIGN_BYTES - 1)) *
                (17 + MUL_W)'(ALIGN_MUL);
    end
    // A size that aligns past 17 bits saturates, so it fits no chunk and
    // exceeds any free total.
    if (state_q == S_ALIGN_SCALE) begin
      rs_q <= align_rs[17] ? '1 : align_rs[16:0];
    end

    if (state_q == S_INIT_WR) begin
      ok_q <= init_ok;
    end

    if (state_q == S_DECIDE) begin
      ok_q    <= dec_ok;
      moved_q <= dec_moved;
      addr_q  <= dec_addr;
      copy_q  <= dec_copy;
      for (int k = 0; k < 3; k++) begin
        wq_en_q[k]  <= dec_wen[k];
        wq_idx_q[k] <= dec_widx[k];
        wq_dat_q[k] <= dec_wdat[k];
      end
      if (step_q == STEP_LOOKUP) begin
        n_idx_q <= s_used_idx;
        n_e_q   <= sres.used_e;
      end
    end

    if (out_load) begin
      out_ok_q    <= ok_q;
      out_moved_q <= moved_q;
      out_addr_q  <= addr_q;
      out_copy_q  <= copy_q;
      out_free_q  <= avail_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_free_q, out_copy_q, out_addr_q};
  assign m_axis_tuser  = {out_moved_q, out_ok_q};

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Arena chunk allocator testbench
// Drives init, alloc, free and realloc requests under all fit policies and
// several arena sizes. A heap model inside a scoreboard class predicts every
// result, and each result transaction is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aca_pkg::*;

  // Expected content of one result transaction.
  typedef struct {
    bit          ok;
    bit [15:0]   addr;
    bit          moved;
    bit [16:0]   copy;
    bit [16:0]   free;
  } heap_result_t;

  // Heap model plus the queue of results still owed by the block.
  class heap_scoreboard;
    bit          vld   [MAX_CHUNKS];
    bit          used  [MAX_CHUNKS];
    int unsigned off   [MAX_CHUNKS];
    int unsigned sz    [MAX_CHUNKS];
    int unsigned stamp [MAX_CHUNKS];
    int unsigned stamp_ctr;
    int unsigned avail;
    int unsigned policy;
    int unsigned arena;
    heap_result_t owed[$];
    int          errors;
    bit [15:0]   last_addr;

    function void clear_all();
      foreach (vld[i]) vld[i] = 0;
      stamp_ctr = 0;
      avail     = 0;
      policy    = 0;
      arena     = 65536;
      errors    = 0;
    endfunction

    function void write_reg(reg_e idx, bit [16:0] val);
      if (idx == REG_FIT_POLICY) policy = val[1:0];
      else arena = val;
    endfunction

    function void mark_free(int i);
      used[i] = 0;
      stamp_ctr++;
      stamp[i] = stamp_ctr;
    endfunction

    // True if chunk a went into the free list more recently than chunk b.
    function bit more_recent(int a, int b);
      if (b < 0) return 1;
      if (stamp[a] != stamp[b]) return stamp[a] > stamp[b];
      return a < b;
    endfunction

    function int find_owner(int unsigned data);
      for (int i = 0; i < MAX_CHUNKS; i++)
        if (vld[i] && used[i] && off[i] + HEADER_BYTES == data) return i;
      return -1;
    endfunction

    function int find_at(int unsigned o);
      for (int i = 0; i < MAX_CHUNKS; i++)
        if (vld[i] && off[i] == o) return i;
      return -1;
    endfunction

    function int find_prev(int unsigned o);
      for (int i = 0; i < MAX_CHUNKS; i++)
        if (vld[i] && off[i] + HEADER_BYTES + sz[i] == o) return i;
      return -1;
    endfunction

    // Fit search over the free chunks.
    function int fit_search(int unsigned want);
      int hit;
      int pick;
      int unsigned s;
      hit  = -1;
      pick = -1;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        if (!vld[i] || used[i]) continue;
        s = sz[i];
        if (s < want) continue;
        if (policy == POL_BEST) begin
          if (s == want) begin
            if (more_recent(i, hit)) hit = i;
          end else if (pick < 0 || s < sz[pick] ||
                       (s == sz[pick] && more_recent(i, pick))) pick = i;
        end else if (policy == POL_WORST) begin
          if (s == avail) begin
            if (more_recent(i, hit)) hit = i;
          end else if (s > 0 && (pick < 0 || s > sz[pick] ||
                       (s == sz[pick] && more_recent(i, pick)))) pick = i;
        end else begin
          if (more_recent(i, pick)) pick = i;
        end
      end
      return (hit >= 0) ? hit : pick;
    endfunction

    function int carve(int unsigned want);
      int n;
      int f;
      int unsigned rest;
      if (want > avail) return -1;
      n = fit_search(want);
      if (n < 0) return -1;
      avail -= sz[n];
      rest = sz[n] - want;
      if (rest >= HEADER_BYTES + ALIGN_BYTES) begin
        f = -1;
        for (int i = 0; i < MAX_CHUNKS; i++)
          if (!vld[i]) begin
            f = i;
            break;
          end
        if (f >= 0) begin
          vld[f] = 1;
          off[f] = off[n] + HEADER_BYTES + want;
          sz[f]  = rest - HEADER_BYTES;
          mark_free(f);
          avail += sz[f];
          sz[n] = want;
        end
      end
      used[n] = 1;
      return n;
    endfunction

    // Release a chunk and merge it with free neighbors, next one first.
    function void release_chunk(int n);
      int s;
      mark_free(n);
      avail += sz[n];
      s = find_at(off[n] + HEADER_BYTES + sz[n]);
      if (s >= 0 && !used[s]) begin
        vld[s] = 0;
        sz[n] += HEADER_BYTES + sz[s];
        avail += HEADER_BYTES;
      end
      s = find_prev(off[n]);
      if (s >= 0 && !used[s]) begin
        vld[n] = 0;
        sz[s] += HEADER_BYTES + sz[n];
        avail += HEADER_BYTES;
      end
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_request(func_e fn, bit [16:0] req, bit [15:0] blk);
      heap_result_t r;
      int unsigned a, rs, origin, ex, es, eo, rest;
      int n, e, f;
      r = '{default: 0};
      rs = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
      case (fn)
        FUNC_INIT: begin
          a = (arena > ARENA_BYTES) ? ARENA_BYTES : arena;
          if (a > 65536) a = 65536;
          foreach (vld[i]) vld[i] = 0;
          stamp_ctr = 0;
          avail = 0;
          if (a > HEADER_BYTES) begin
            vld[0] = 1;
            off[0] = 0;
            sz[0]  = a - HEADER_BYTES;
            mark_free(0);
            avail = sz[0];
            r.ok = 1;
          end
        end
        FUNC_ALLOC: begin
          n = carve(rs);
          if (n >= 0) begin
            r.ok = 1;
            r.addr = off[n] + HEADER_BYTES;
          end
        end
        FUNC_FREE: begin
          n = find_owner(blk);
          if (n >= 0) begin
            release_chunk(n);
            r.ok = 1;
          end
        end
        default: begin
          n = find_owner(blk);
          if (n >= 0 && rs <= avail) begin
            origin = sz[n];
            if (origin >= rs) begin
              r.ok = 1;
              r.addr = blk;
            end else begin
              ex = rs - origin;
              e = find_at(off[n] + HEADER_BYTES + origin);
              if (e < 0 || used[e] || HEADER_BYTES + sz[e] < ex) begin
                // No room behind the block: move it.
                f = carve(rs);
                if (f >= 0) begin
                  r.addr = off[f] + HEADER_BYTES;
                  release_chunk(n);
                  r.ok = 1;
                  r.moved = 1;
                  r.copy = origin;
                end
              end else begin
                // Grow in place into the free successor.
                es = sz[e];
                eo = off[e];
                rest = HEADER_BYTES + es - ex;
                avail -= es;
                vld[e] = 0;
                if (rest < HEADER_BYTES + ALIGN_BYTES) begin
                  rs = origin + HEADER_BYTES + es;
                end else begin
                  vld[e] = 1;
                  off[e] = eo + ex;
                  sz[e]  = rest - HEADER_BYTES;
                  mark_free(e);
                  avail += sz[e];
                end
                sz[n] = rs;
                r.ok = 1;
                r.addr = blk;
              end
            end
          end
        end
      endcase
      r.free = avail;
      last_addr = r.addr;
      owed.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t w;
      if (owed.size() == 0) begin
        $display("%0t: result with none expected: ok=%0d addr=%0h free=%0d",
                 $time, got.ok, got.addr, got.free);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (got.ok !== w.ok) begin
        $display("%0t: ok expected %0d actual %0d", $time, w.ok, got.ok);
        errors++;
      end
      if (got.addr !== w.addr) begin
        $display("%0t: data_address expected %0h actual %0h", $time, w.addr, got.addr);
        errors++;
      end
      if (got.moved !== w.moved) begin
        $display("%0t: moved expected %0d actual %0d", $time, w.moved, got.moved);
        errors++;
      end
      if (got.copy !== w.copy) begin
        $display("%0t: copy_bytes expected %0d actual %0d", $time, w.copy, got.copy);
        errors++;
      end
      if (got.free !== w.free) begin
        $display("%0t: free_bytes expected %0d actual %0d", $time, w.free, got.free);
        errors++;
      end
    endfunction

    // Data address of a random block in use, or noise if none is live.
    function bit [15:0] live_block();
      int ids[$];
      for (int i = 0; i < MAX_CHUNKS; i++)
        if (vld[i] && used[i]) ids.push_back(i);
      if (ids.size() == 0) return 16'($urandom);
      return 16'(off[ids[$urandom_range(0, ids.size() - 1)]] + HEADER_BYTES);
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  heap_scoreboard sb = new();
  bit hold_req = 0;
  int burst_left = 0;

  arena_chunk_allocator uut (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // Give up if the run hangs.
  initial begin
    #300ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Result receiver: random stall pattern, with a long hold on request.
  initial begin
    int mode;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 0;
        repeat (5000) @(negedge clk_i);
        hold_req = 0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        case (mode)
          0:       m_axis_tready <= 1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(negedge clk_i);
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    heap_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok    = m_axis_tuser[0];
      got.moved = m_axis_tuser[1];
      got.addr  = m_axis_tdata[15:0];
      got.copy  = m_axis_tdata[32:16];
      got.free  = m_axis_tdata[49:33];
      sb.check_result(got);
    end
  end

  // Offer one request transaction; gaps follow bursts of random length.
  task automatic send_req(func_e fn, bit [16:0] req, bit [15:0] blk);
    @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {7'b0, blk, req};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(fn, req, blk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 0;
        repeat ($urandom_range(0, 30)) @(negedge clk_i);
      end
    end
  endtask

  task automatic write_reg(reg_e idx, bit [16:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Stop offering and wait until every owed result has arrived.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // One random request, mostly well formed against the live blocks.
  task automatic random_req();
    int r;
    bit [16:0] size;
    r = $urandom_range(0, 99);
    size = ($urandom_range(0, 19) == 0) ? 17'($urandom_range(0, 65536))
                                        : 17'($urandom_range(0, 700));
    if (r < 40)      send_req(FUNC_ALLOC, size, 16'($urandom));
    else if (r < 63) send_req(FUNC_FREE, 17'($urandom), sb.live_block());
    else if (r < 85) send_req(FUNC_REALLOC, size, sb.live_block());
    else if (r < 91) send_req(func_e'($urandom_range(2, 3)), size, 16'($urandom));
    else if (r < 93) send_req(FUNC_INIT, 17'($urandom), 16'($urandom));
    else             send_req(FUNC_ALLOC, 17'($urandom_range(0, 65536)), 16'($urandom));
  endtask

  initial begin
    bit [15:0] a0, a1, a2;
    bit [16:0] arenas [6];
    bit [1:0]  pols [6];
    arenas = '{17'd65536, 17'd65535, 17'd4096, 17'd48, 17'd0, 17'd1000};
    pols   = '{POL_FIRST, POL_BEST, POL_WORST, POL_FIRST_ALT, POL_BEST, POL_WORST};
    arenas[4] = 17'($urandom_range(48, 65536));
    sb.clear_all();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed opening: request before init, split, grow, move, merge.
    send_req(FUNC_ALLOC, 17'd16, 16'd0);
    send_req(FUNC_FREE, 17'd0, 16'hFFFF);
    send_req(FUNC_INIT, 17'd0, 16'd0);
    send_req(FUNC_ALLOC, 17'd0, 16'd0);
    a0 = sb.last_addr;
    send_req(FUNC_ALLOC, 17'd1, 16'd0);
    a1 = sb.last_addr;
    send_req(FUNC_ALLOC, 17'd100, 16'd0);
    a2 = sb.last_addr;
    send_req(FUNC_ALLOC, 17'd65536, 16'd0);
    send_req(FUNC_REALLOC, 17'd8, a1);
    send_req(FUNC_REALLOC, 17'd164, a2);
    send_req(FUNC_REALLOC, 17'd200, a1);
    send_req(FUNC_FREE, 17'd0, a0);
    send_req(FUNC_FREE, 17'd0, a2);
    send_req(FUNC_FREE, 17'd0, a2);
    send_req(FUNC_REALLOC, 17'd10, 16'h1234);
    send_req(FUNC_ALLOC, 17'd65535, 16'd0);
    send_req(FUNC_ALLOC, 17'd65456, 16'd0);
    send_req(FUNC_REALLOC, 17'h1FFFF, sb.last_addr);
    drain();

    // Phases across fit policies and arena sizes, each starting with init.
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_FIT_POLICY, 17'(pols[p]));
      write_reg(REG_ARENA_BYTES, arenas[p]);
      send_req(FUNC_INIT, 17'd0, 16'd0);
      if (p == 1) hold_req = 1;
      repeat (94) random_req();
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
